[sv/p2a_pkg.sv]
// ----------------------------------------------------------------------------
// p2a_pkg
// types, constants and small lookup functions shared by the pixel to cell path
// ----------------------------------------------------------------------------
package p2a_pkg;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } pixel_t;

  typedef struct packed {
    logic [3:0] palette_index;
    logic [6:0] back_code;
    logic [6:0] fore_code;
    logic [6:0] glyph;
  } cell_t;

  // luma weights, y = (77r + 150g + 29b) >> 8
  localparam logic [7:0] LUMA_WR = 8'd77;
  localparam logic [7:0] LUMA_WG = 8'd150;
  localparam logic [7:0] LUMA_WB = 8'd29;

  localparam int unsigned BAND_SIZE = 86;
  localparam int unsigned RAMP_LEN  = 15;

  localparam logic [7:0] BAND1_START = 8'(BAND_SIZE);
  localparam logic [7:0] BAND2_START = 8'(2 * BAND_SIZE);

  // palette levels: dim half uses 0/187, bright half uses 85/255
  localparam logic [7:0] DIM_LOW     = 8'd0;
  localparam logic [7:0] DIM_HIGH    = 8'd187;
  localparam logic [7:0] BRIGHT_LOW  = 8'd85;
  localparam logic [7:0] BRIGHT_HIGH = 8'd255;
  // first level that is strictly nearer the high level (midpoint rounded up past ties)
  localparam logic [7:0] DIM_SPLIT    = 8'((DIM_LOW + DIM_HIGH) / 2 + 1);
  localparam logic [7:0] BRIGHT_SPLIT = 8'((BRIGHT_LOW + BRIGHT_HIGH) / 2 + 1);

  localparam logic [6:0] CODE_BASE_DIM    = 7'd30;
  localparam logic [6:0] CODE_BASE_BRIGHT = 7'd90;
  localparam logic [6:0] BACK_DARK        = 7'd40;
  localparam logic [6:0] BACK_LIGHT       = 7'd107;
  localparam logic [6:0] FORE_MID         = 7'd97;
  localparam logic [6:0] BACK_OFFSET      = 7'd10;

  localparam logic [1:0] BAND_DARK  = 2'd0;
  localparam logic [1:0] BAND_MID   = 2'd1;
  localparam logic [1:0] BAND_LIGHT = 2'd2;

  function automatic logic [6:0] palette_code(input logic [3:0] idx);
    logic [6:0] base;
    base = idx[3] ? CODE_BASE_BRIGHT : CODE_BASE_DIM;
    return base + {4'd0, idx[2:0]};
  endfunction

  // 15 * rem / 86 as a bank of independent threshold compares
  function automatic logic [3:0] ramp_pos(input logic [6:0] rem);
    logic [10:0] scaled;
    logic [RAMP_LEN-2:0] above;
    scaled = 11'(rem) * 11'(RAMP_LEN);
    for (int k = 1; k < RAMP_LEN; k++) begin
      above[k-1] = (scaled >= 11'(k * BAND_SIZE));
    end
    return 4'($countones(above));
  endfunction

  // light-first ramp " `.-+:soamyhdNM"
  function automatic logic [6:0] ramp_char(input logic [3:0] pos);
    logic [6:0] ch;
    case (pos)
      4'd0:    ch = 7'd32;   // space
      4'd1:    ch = 7'd96;   // backtick
      4'd2:    ch = 7'd46;   // .
      4'd3:    ch = 7'd45;   // -
      4'd4:    ch = 7'd43;   // +
      4'd5:    ch = 7'd58;   // :
      4'd6:    ch = 7'd115;  // s
      4'd7:    ch = 7'd111;  // o
      4'd8:    ch = 7'd97;   // a
      4'd9:    ch = 7'd109;  // m
      4'd10:   ch = 7'd121;  // y
      4'd11:   ch = 7'd104;  // h
      4'd12:   ch = 7'd100;  // d
      4'd13:   ch = 7'd78;   // N
      4'd14:   ch = 7'd77;   // M
      default: ch = 7'd77;
    endcase
    return ch;
  endfunction

endpackage

[sv/p2a_nearest.sv]
// ----------------------------------------------------------------------------
// p2a_nearest
// nearest of the 16 palette colours by squared rgb distance, lowest index on tie
// ----------------------------------------------------------------------------
module p2a_nearest
  import p2a_pkg::*;
(
  input  pixel_t     pix,
  output logic [3:0] index
);

  // each half of the palette is a 2x2x2 cube, so the best entry in a half is
  // picked channel by channel; ties stay on the low level (lower index)
  function automatic logic [6:0] level_diff(input logic [7:0] x, input logic [7:0] lvl);
    logic [7:0] d;
    d = (x >= lvl) ? (x - lvl) : (lvl - x);
    return d[6:0];
  endfunction

  logic [2:0]  dim_sel, bright_sel;
  logic [6:0]  dim_d [3];
  logic [6:0]  bright_d [3];
  logic [15:0] dim_dist, bright_dist;
  logic [7:0]  chan [3];

  assign chan[0] = pix.red_level;
  assign chan[1] = pix.green_level;
  assign chan[2] = pix.blue_level;

  always_comb begin
    dim_dist    = '0;
    bright_dist = '0;
    for (int c = 0; c < 3; c++) begin
      dim_sel[c]    = (chan[c] >= DIM_SPLIT);
      bright_sel[c] = (chan[c] >= BRIGHT_SPLIT);
      dim_d[c]      = level_diff(chan[c], dim_sel[c] ? DIM_HIGH : DIM_LOW);
      bright_d[c]   = level_diff(chan[c], bright_sel[c] ? BRIGHT_HIGH : BRIGHT_LOW);
      dim_dist      = dim_dist + 16'(14'(dim_d[c]) * 14'(dim_d[c]));
      bright_dist   = bright_dist + 16'(14'(bright_d[c]) * 14'(bright_d[c]));
    end
  end

  // bit 0 red, bit 1 green, bit 2 blue, bit 3 bright half
  assign index = (bright_dist < dim_dist) ? {1'b1, bright_sel} : {1'b0, dim_sel};

endmodule

[sv/pixel_to_ansi_cell.sv]
// ----------------------------------------------------------------------------
// pixel_to_ansi_cell
// maps one rgb pixel to one terminal character cell: palette colour, ansi
// background and foreground codes, and a luma-driven ramp glyph
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_ready | in_data  (pixel_t: red, green, blue)
//   out     | out_valid/out_ready | out_data (cell_t: index, back, fore, glyph)
//
// - every transaction passes through the input register, one pass of
//   combinational logic and the result register
// - one transaction per cycle sustained while out_ready is high; the path
//   is set by the palette distance compare feeding the result register
// - reset (rst_n, synchronous) empties both registers; no other state
// - a stalled result holds the input register too; in_ready falls only when
//   both registers are full and out_ready is low
//
module pixel_to_ansi_cell
  import p2a_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output cell_t  out_data
);

  // stage registers
  logic   s1_v_r, s1_v_nxt;
  pixel_t s1_pix_r;
  logic   out_v_r, out_v_nxt;
  cell_t  out_cell_r;

  logic   s1_adv;      // stage 1 may move into the result register
  logic   in_take;     // input transaction this cycle

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  // ---------------------------------------------------------------- datapath
  logic [3:0]  best_idx;
  logic [15:0] luma_sum;
  logic [7:0]  luma;
  logic [1:0]  band;
  logic [7:0]  band_base;
  logic [7:0]  rem_full;
  logic [3:0]  pos;
  logic [6:0]  code;
  cell_t       cell_nxt;

  p2a_nearest u_nearest (
    .pix   (s1_pix_r),
    .index (best_idx)
  );

  // fixed-point luma, max 65280 so 16 bits hold the sum
  assign luma_sum = 16'(s1_pix_r.red_level)   * 16'(LUMA_WR)
                  + 16'(s1_pix_r.green_level) * 16'(LUMA_WG)
                  + 16'(s1_pix_r.blue_level)  * 16'(LUMA_WB);
  assign luma     = luma_sum[15:8];

  // three darkness bands starting at luma 0, 86 and 172
  always_comb begin
    if (luma >= BAND2_START) begin
      band      = BAND_LIGHT;
      band_base = BAND2_START;
    end else if (luma >= BAND1_START) begin
      band      = BAND_MID;
      band_base = BAND1_START;
    end else begin
      band      = BAND_DARK;
      band_base = '0;
    end
  end

  assign rem_full = luma - band_base;
  assign pos      = ramp_pos(rem_full[6:0]);
  assign code     = palette_code(best_idx);

  always_comb begin
    cell_nxt.palette_index = best_idx;
    case (band)
      BAND_DARK: begin
        cell_nxt.back_code = BACK_DARK;
        cell_nxt.fore_code = code;
        cell_nxt.glyph     = ramp_char(pos);
      end
      BAND_MID: begin
        cell_nxt.back_code = code + BACK_OFFSET;
        cell_nxt.fore_code = FORE_MID;
        cell_nxt.glyph     = ramp_char(pos);
      end
      default: begin
        // light band runs the ramp the other way round
        cell_nxt.back_code = BACK_LIGHT;
        cell_nxt.fore_code = code;
        cell_nxt.glyph     = ramp_char(4'(RAMP_LEN - 1) - pos);
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
    end
    if (in_ready) begin
      s1_v_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix_r <= in_data;
    end
    if (s1_adv && s1_v_r) begin
      out_cell_r <= cell_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_cell_r;

`ifndef ASSERT_OFF
  // a full stage 1 behind a stalled result keeps its pixel
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |=> (s1_v_r && $stable(s1_pix_r)))
    else $error("stage 1 lost or changed while stalled");

  // a pixel leaving stage 1 always lands in the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv) |=> out_v_r)
    else $error("stage 1 item dropped");

  // background and foreground codes agree with the palette index
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |->
      ((out_cell_r.back_code == BACK_DARK &&
        out_cell_r.fore_code == palette_code(out_cell_r.palette_index)) ||
       (out_cell_r.back_code == BACK_LIGHT &&
        out_cell_r.fore_code == palette_code(out_cell_r.palette_index)) ||
       (out_cell_r.fore_code == FORE_MID &&
        out_cell_r.back_code == palette_code(out_cell_r.palette_index) + BACK_OFFSET)))
    else $error("colour codes inconsistent with palette index");

  // glyph is printable ascii
  a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_cell_r.glyph >= 7'd32 && out_cell_r.glyph <= 7'd126))
    else $error("glyph outside printable range");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: pixel to ansi cell testbench
// Drives rgb pixels into pixel_to_ansi_cell over a valid/ready channel and
// checks every character cell it returns against an independent prediction
// of palette match, ansi codes and ramp glyph. Directed pixels go first,
// then random pixels shaped around palette colours and decision boundaries.
// Random sender bursts and receiver stalls run throughout.
// ----------------------------------------------------------------------------
module tb_top
  import p2a_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int unsigned RANDOM_PIXELS = 1250;
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int unsigned DRAIN_CYCLES  = 10;    // input and result registers, plus margin
  localparam int unsigned TIE_TARGET    = 8;

  // cell encoding, kept apart from the rtl package on purpose
  localparam int unsigned LUMA_R      = 77;
  localparam int unsigned LUMA_G      = 150;
  localparam int unsigned LUMA_B      = 29;
  localparam int unsigned BAND_WIDTH  = 86;
  localparam int unsigned RAMP_STEPS  = 15;
  localparam logic [6:0]  BACK_BLACK  = 7'd40;
  localparam logic [6:0]  BACK_WHITE  = 7'd107;
  localparam logic [6:0]  FORE_WHITE  = 7'd97;
  localparam logic [6:0]  BACK_SHIFT  = 7'd10;
  localparam logic [6:0]  DIM_BASE    = 7'd30;
  localparam logic [6:0]  BRIGHT_BASE = 7'd90;

  // ramps as packed strings, first character in the top byte
  localparam logic [8*15-1:0] RAMP_LIGHT_FIRST = " `.-+:soamyhdNM";
  localparam logic [8*15-1:0] RAMP_DARK_FIRST  = "MNdhymaos:+-.` ";

  typedef enum logic [1:0] {DARK_BAND, MID_BAND, LIGHT_BAND} band_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SLOW, RX_EVERY_THIRD} rx_mode_t;
  typedef enum logic [2:0] {
    PX_UNIFORM, PX_NEAR_PALETTE, PX_GREY, PX_BOUNDARY, PX_EXTREME
  } pixel_kind_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  pixel_t in_data;
  logic   out_valid;
  logic   out_ready;
  cell_t  out_data;

  cell_t       pending_cells[$];   // predicted cells, oldest first
  int unsigned n_pixels;
  int unsigned n_cells;
  int unsigned n_errors;
  int unsigned n_ties;
  int unsigned n_in_stalls;
  int unsigned burst_left;
  logic [15:0] palette_hit;
  logic        hold_rx;            // request for one long receiver hold-off

  pixel_to_ansi_cell DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  function automatic pixel_t rgb(input int unsigned r, input int unsigned g,
                                 input int unsigned b);
    pixel_t px;
    px.red_level   = r[7:0];
    px.green_level = g[7:0];
    px.blue_level  = b[7:0];
    return px;
  endfunction

  // palette entry: bit 0 red, bit 1 green, bit 2 blue, bit 3 selects the
  // bright half (85/255) over the dim half (0/187)
  function automatic pixel_t palette_colour(input logic [3:0] idx);
    int unsigned lo, hi;
    lo = idx[3] ? 85 : 0;
    hi = idx[3] ? 255 : 187;
    return rgb(idx[0] ? hi : lo, idx[1] ? hi : lo, idx[2] ? hi : lo);
  endfunction

  // nearest palette entry by squared rgb distance, lowest index on a tie;
  // tied reports whether the winning distance was shared
  function automatic logic [3:0] nearest_palette(input pixel_t px, output logic tied);
    pixel_t      pal;
    int          dr, dg, db;
    int unsigned sq_dist, best_dist;
    logic [3:0]  best;
    best      = 4'd0;
    best_dist = 32'hFFFF_FFFF;
    tied      = 1'b0;
    for (int i = 0; i < 16; i++) begin
      pal     = palette_colour(4'(i));
      dr      = int'(px.red_level) - int'(pal.red_level);
      dg      = int'(px.green_level) - int'(pal.green_level);
      db      = int'(px.blue_level) - int'(pal.blue_level);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < best_dist) begin
        best_dist = sq_dist;
        best      = 4'(i);
        tied      = 1'b0;
      end else if (sq_dist == best_dist) begin
        tied = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic cell_t ansi_cell_of(input pixel_t px);
    cell_t       c;
    logic        tied;
    logic [3:0]  idx;
    logic [6:0]  code;
    int unsigned luma, step;
    band_t       band;
    idx  = nearest_palette(px, tied);
    code = (idx[3] ? BRIGHT_BASE : DIM_BASE) + 7'(idx[2:0]);
    luma = (LUMA_R * px.red_level + LUMA_G * px.green_level
            + LUMA_B * px.blue_level) >> 8;
    band = band_t'(luma / BAND_WIDTH);
    step = (RAMP_STEPS * (luma % BAND_WIDTH)) / BAND_WIDTH;
    if (step > RAMP_STEPS - 1) step = RAMP_STEPS - 1;

    c.palette_index = idx;
    case (band)
      DARK_BAND: begin
        c.back_code = BACK_BLACK;
        c.fore_code = code;
      end
      MID_BAND: begin
        c.back_code = code + BACK_SHIFT;
        c.fore_code = FORE_WHITE;
      end
      default: begin
        c.back_code = BACK_WHITE;
        c.fore_code = code;
      end
    endcase
    // light band walks the ramp the other way round
    if (band == LIGHT_BAND)
      c.glyph = RAMP_DARK_FIRST[8 * (RAMP_STEPS - 1 - step) +: 7];
    else
      c.glyph = RAMP_LIGHT_FIRST[8 * (RAMP_STEPS - 1 - step) +: 7];
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // scoreboard: check the cell leaving first, then log the pixel entering,
  // both from pre-edge values so the order of processes does not matter
  // --------------------------------------------------------------------------

  function automatic void check_field(input string what, input logic [6:0] want,
                                      input logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    cell_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_cells.size() == 0) begin
          $display("%0t: cell with nothing pending, expected none, got %h",
                   $time, out_data);
          n_errors++;
        end else begin
          want = pending_cells.pop_front();
          check_field("palette_index", 7'(want.palette_index), 7'(out_data.palette_index));
          check_field("back_code", want.back_code, out_data.back_code);
          check_field("fore_code", want.fore_code, out_data.fore_code);
          check_field("glyph", want.glyph, out_data.glyph);
          n_cells++;
        end
      end
      if (in_valid && in_ready) begin
        want = ansi_cell_of(in_data);
        pending_cells.push_back(want);
        palette_hit[want.palette_index] = 1'b1;
        n_pixels++;
      end
      if (in_valid && !in_ready) n_in_stalls++;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: switches between randomly chosen stall patterns and
  // honours one long hold-off on request
  // --------------------------------------------------------------------------

  initial begin : receiver
    rx_mode_t    mode;
    int unsigned left;
    out_ready = 1'b0;
    mode      = RX_ALWAYS;
    left      = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          RX_ALWAYS:      out_ready <= 1'b1;
          RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
          RX_SLOW:        out_ready <= ($urandom_range(0, 3) == 0);
          RX_EVERY_THIRD: out_ready <= (left % 3 == 0);
          default:        out_ready <= 1'b1;
        endcase
      end
    end
  end

  // watchdog: gives up once nothing has moved on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("[pixel_to_ansi_cell] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------

  // offer one pixel and return on the edge that takes it; valid stays up
  // between pixels of a burst and drops only for a gap
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait for every pending cell to come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned jitter(input int unsigned level, input int unsigned span);
    int v;
    v = int'(level) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // levels where the per-channel palette choice flips, and the rails
  function automatic int unsigned boundary_level();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(92, 95);     // between 0 and 187
      1:       return $urandom_range(168, 172);   // between 85 and 255
      2:       return $urandom_range(125, 130);   // dim high against bright low
      3:       return 0;
      4:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic pixel_t draw_pixel();
    pixel_t      pal;
    int unsigned v, span;
    case (pixel_kind_t'($urandom_range(0, 4)))
      PX_NEAR_PALETTE: begin
        pal  = palette_colour(4'($urandom_range(0, 15)));
        span = ($urandom_range(0, 1) == 0) ? 4 : 48;
        return rgb(jitter(pal.red_level, span), jitter(pal.green_level, span),
                   jitter(pal.blue_level, span));
      end
      PX_GREY: begin
        v = $urandom_range(0, 255);
        return rgb(v, jitter(v, 2), jitter(v, 2));
      end
      PX_BOUNDARY: return rgb(boundary_level(), boundary_level(), boundary_level());
      PX_EXTREME: begin
        return rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                   $urandom_range(0, 1) * 255);
      end
      default: return pixel_t'(24'($urandom));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every palette colour exactly, then the pure full-scale primaries
  task automatic test_palette_colours();
    for (int i = 0; i < 16; i++) send_pixel(palette_colour(4'(i)));
    send_pixel(rgb(255, 0, 0));
    send_pixel(rgb(0, 255, 0));
    send_pixel(rgb(0, 0, 255));
  endtask

  // grey pixels have luma equal to their level: hit both band edges
  task automatic test_luma_bands();
    send_pixel(rgb(86, 86, 86));
    send_pixel(rgb(171, 171, 171));
    send_pixel(rgb(172, 172, 172));
  endtask

  // equal distance to two palette entries, lower index must win
  task automatic test_distance_ties();
    pixel_t      px;
    logic        tied;
    logic [3:0]  idx;
    int unsigned tries;
    send_pixel(rgb(186, 56, 57));   // dim red against bright red
    send_pixel(rgb(131, 40, 39));   // dim red against grey
    n_ties += 2;
    tries = 0;
    while (tries < 200000 && n_ties < TIE_TARGET + 2) begin
      px  = draw_pixel();
      idx = nearest_palette(px, tied);
      if (tied) begin
        send_pixel(px);
        n_ties++;
      end
      tries++;
    end
  endtask

  // receiver holds off for a long stretch while a full burst keeps coming,
  // so the pipe fills and in_ready has to drop
  task automatic test_backpressure();
    settle();
    hold_rx    = 1'b1;
    burst_left = 40;
    repeat (40) send_pixel(draw_pixel());
    settle();
  endtask

  // bursts separated by full drains
  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(5, 15)) send_pixel(draw_pixel());
      settle();
    end
  endtask

  task automatic test_random_pixels();
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      send_pixel(draw_pixel());
      if ($urandom_range(0, 299) == 0) settle();
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin : run
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    hold_rx     = 1'b0;
    n_pixels    = 0;
    n_cells     = 0;
    n_errors    = 0;
    n_ties      = 0;
    n_in_stalls = 0;
    burst_left  = 0;
    palette_hit = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_palette_colours();
    test_luma_bands();
    test_distance_ties();
    test_backpressure();
    test_drain_pause();
    test_random_pixels();

    // nothing pending now; give a stray late cell time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels in, %0d cells checked, %0d of 16 palette colours matched",
             n_pixels, n_cells, $countones(palette_hit));
    $display("%0d tied pixels, %0d cycles with the input stalled", n_ties, n_in_stalls);
    if (n_errors == 0) begin
      $display("[pixel_to_ansi_cell] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[pixel_to_ansi_cell] ERROR");
    end
    $finish;
  end

endmodule
